### rtl/bcdec_pkg.sv
// bcdec_pkg: shared types and constants for the bc1/bc2 block decoder
// used by bcdec_front, bcdec_queue, bcdec_back and the top level
`default_nettype none

package bcdec_pkg;

  localparam int PIX_PER_BLK     = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [3:0] PIX_LAST     = 4'(PIX_PER_BLK - 1);
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic {
    FMT_DXT1 = 1'b0,
    FMT_DXT3 = 1'b1
  } blk_fmt_t;

  // one classified block, ready for pixel emission
  typedef struct packed {
    logic [3:0][23:0] pal;        // rgb palette, entry per 2-bit index
    logic             four_color; // low means index 3 is transparent black
    logic             dxt3;       // alpha comes from alpha nibbles
    logic [31:0]      idx;        // 2-bit index per pixel
    logic [63:0]      alpha;      // 4-bit alpha per pixel
  } blk_rec_t;

endpackage

`default_nettype wire

### rtl/bcdec_front.sv
// bcdec_front: accepts compressed blocks, holds the format register and
// builds the palette record; depends on bcdec_pkg
`default_nettype none

module bcdec_front (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_push,
  output logic                     in_full,
  input  wire  [63:0]              in_color_block,
  input  wire  [63:0]              in_alpha_block,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire                      cfg_block_format,
  output logic                     q_push,
  input  wire                      q_full,
  output bcdec_pkg::blk_rec_t      q_data
);
  import bcdec_pkg::*;

  blk_fmt_t fmt_r;

  logic [15:0] e0, e1;
  logic [7:0]  ar, ag, ab, br, bg, bb;
  logic        dxt3;
  logic        four;

  // (2x + y + 1) / 3 via reciprocal: s * 683 >> 11 is exact for s < 2048
  function automatic logic [7:0] mix_third(input logic [7:0] x, input logic [7:0] y);
    logic [9:0]  s;
    logic [19:0] p;
    s = {1'b0, x, 1'b0} + {2'b00, y} + 10'd1;
    p = 20'(s) * 20'd683;
    return p[18:11];
  endfunction

  function automatic logic [7:0] mix_half(input logic [7:0] x, input logic [7:0] y);
    logic [8:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[8:1];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_DXT1;
    end else if (cfg_valid && cfg_ready) begin
      fmt_r <= blk_fmt_t'(cfg_block_format);
    end
  end

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;
  assign q_push    = in_push & ~q_full;

  always_comb begin
    e0   = in_color_block[15:0];
    e1   = in_color_block[31:16];
    // 565 widened by shifting only
    ar   = {e0[15:11], 3'b000};
    ag   = {e0[10:5], 2'b00};
    ab   = {e0[4:0], 3'b000};
    br   = {e1[15:11], 3'b000};
    bg   = {e1[10:5], 2'b00};
    bb   = {e1[4:0], 3'b000};
    dxt3 = (fmt_r == FMT_DXT3);
    four = dxt3 || (e0 > e1);

    q_data.pal[0] = {ar, ag, ab};
    q_data.pal[1] = {br, bg, bb};
    if (four) begin
      q_data.pal[2] = {mix_third(ar, br), mix_third(ag, bg), mix_third(ab, bb)};
      q_data.pal[3] = {mix_third(br, ar), mix_third(bg, ag), mix_third(bb, ab)};
    end else begin
      q_data.pal[2] = {mix_half(ar, br), mix_half(ag, bg), mix_half(ab, bb)};
      q_data.pal[3] = 24'h000000;
    end
    q_data.four_color = four;
    q_data.dxt3       = dxt3;
    q_data.idx        = in_color_block[63:32];
    q_data.alpha      = in_alpha_block;
  end

endmodule

`default_nettype wire

### rtl/bcdec_queue.sv
// bcdec_queue: short first-in first-out queue of block records between
// the front and back parts; depends on bcdec_pkg
`default_nettype none

module bcdec_queue #(
  parameter int DEPTH = bcdec_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      push,
  output logic                     full,
  input  bcdec_pkg::blk_rec_t      wr_data,
  input  wire                      pop,
  output logic                     empty,
  output bcdec_pkg::blk_rec_t      rd_data
);
  import bcdec_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  blk_rec_t      slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### rtl/bcdec_back.sv
// bcdec_back: walks the head block record one pixel per cycle into the
// result register while it is free or popped; depends on bcdec_pkg
`default_nettype none

module bcdec_back (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      q_empty,
  input  bcdec_pkg::blk_rec_t      q_data,
  output logic                     q_pop,
  output logic                     out_empty,
  input  wire                      out_pop,
  output logic [31:0]              out_pixel_argb,
  output logic [3:0]               out_pixel_number,
  output logic                     out_last_pixel
);
  import bcdec_pkg::*;

  logic [3:0]  pix_cnt_r, pix_cnt_nxt;
  logic        out_vld_r, out_vld_nxt;
  logic [31:0] argb_r;
  logic [3:0]  num_r;
  logic        last_r;

  logic        load;
  logic [1:0]  pix_idx;
  logic [3:0]  nib;
  logic [7:0]  alpha;
  logic [31:0] argb;

  // result register frees up in the same cycle its transfer happens
  assign load  = ~q_empty & (~out_vld_r | out_pop);
  assign q_pop = load & (pix_cnt_r == PIX_LAST);

  always_comb begin
    pix_idx = q_data.idx[{pix_cnt_r, 1'b0} +: 2];
    nib     = q_data.alpha[{pix_cnt_r, 2'b00} +: 4];
    if (q_data.dxt3) begin
      alpha = {nib, nib};  // nibble times 17
    end else if (pix_idx == 2'd3 && !q_data.four_color) begin
      alpha = 8'h00;
    end else begin
      alpha = ALPHA_OPAQUE;
    end
    argb = {alpha, q_data.pal[pix_idx]};

    pix_cnt_nxt = load ? pix_cnt_r + 4'd1 : pix_cnt_r;
    if (load) begin
      out_vld_nxt = 1'b1;
    end else if (out_pop) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_cnt_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      pix_cnt_r <= pix_cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      argb_r <= argb;
      num_r  <= pix_cnt_r;
      last_r <= (pix_cnt_r == PIX_LAST);
    end
  end

  assign out_empty        = ~out_vld_r;
  assign out_pixel_argb   = argb_r;
  assign out_pixel_number = num_r;
  assign out_last_pixel   = last_r;

endmodule

`default_nettype wire

### rtl/bc1_bc2_block_decoder_unit.sv
// bc1_bc2_block_decoder_unit: decodes one 4x4 dxt1/dxt3 block into 16 argb pixels
// a block's first pixel reaches the result ports through its queue slot and then the result register
// throughput: one pixel per cycle out of the back pixel counter while the result register is free or popped
// the block queue lets the next block transfer in while the current one drains
// reset: queue and result register empty, pixel counter at zero, format dxt1
// depends on bcdec_pkg, bcdec_front, bcdec_queue, bcdec_back
`default_nettype none

module bc1_bc2_block_decoder_unit #(
  parameter int QUEUE_DEPTH = bcdec_pkg::QUEUE_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_push,
  output logic        in_full,
  input  wire  [63:0] in_color_block,
  input  wire  [63:0] in_alpha_block,
  output logic        out_empty,
  input  wire         out_pop,
  output logic [31:0] out_pixel_argb,
  output logic [3:0]  out_pixel_number,
  output logic        out_last_pixel,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire         cfg_block_format
);
  import bcdec_pkg::*;

  blk_rec_t wr_rec, rd_rec;
  logic     q_push, q_full, q_pop, q_empty;

  bcdec_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_color_block   (in_color_block),
    .in_alpha_block   (in_alpha_block),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_block_format (cfg_block_format),
    .q_push           (q_push),
    .q_full           (q_full),
    .q_data           (wr_rec)
  );

  bcdec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .full    (q_full),
    .wr_data (wr_rec),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (rd_rec)
  );

  bcdec_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_data           (rd_rec),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_pixel_argb   (out_pixel_argb),
    .out_pixel_number (out_pixel_number),
    .out_last_pixel   (out_last_pixel)
  );

endmodule

`default_nettype wire
